FILE: rtl/fcba_pkg.sv
// Shared types for the chain block allocator: command codes and controller states.
// No dependencies; imported by fcba_ctrl and the top level.

package fcba_pkg;

  // Command codes carried on the cmd field of an input word
  typedef enum logic [1:0] {
    CMD_FORMAT = 2'd0,
    CMD_ALLOC  = 2'd1,
    CMD_FREE   = 2'd2,
    CMD_READ   = 2'd3
  } cmd_t;

  // Controller states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_SCAN,
    ST_LINK_END,
    ST_WALK_RD,
    ST_WALK_WR,
    ST_RESP
  } state_t;

endpackage

FILE: rtl/fcba_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// No dependencies.

module fcba_ram #(
  parameter int WIDTH = 11,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/fcba_ctrl.sv
// Allocator controller: command sequencer, table scan and chain walk over the link RAM.
// Depends on fcba_pkg; drives the ports of one fcba_ram instance.

module fcba_ctrl #(
  parameter int MAX_BLOCKS = 1024,
  parameter int BW = $clog2(MAX_BLOCKS + 2),
  parameter int IW = $clog2(MAX_BLOCKS)
) (
  input  logic               clk,
  input  logic               rst,
  // input word
  input  logic               in_valid,
  output logic               in_ready,
  input  fcba_pkg::cmd_t     cmd,
  input  logic [BW-1:0]      req_blocks,
  input  logic [BW-1:0]      chain_head,
  input  logic [IW-1:0]      entry_index,
  // configuration
  input  logic [BW-1:0]      disk_blocks,
  // result towards the output register
  output logic               res_valid,
  input  logic               res_take,
  output logic               res_ok,
  output logic [BW-1:0]      res_first,
  output logic [BW-1:0]      res_count,
  output logic [BW-1:0]      res_value,
  output logic [BW-1:0]      free_left,
  // link RAM
  output logic               ram_we,
  output logic [IW-1:0]      ram_waddr,
  output logic [BW-1:0]      ram_wdata,
  output logic               ram_re,
  output logic [IW-1:0]      ram_raddr,
  input  logic [BW-1:0]      ram_rdata
);

  import fcba_pkg::*;

  localparam logic [BW-1:0] MARK_END  = BW'(MAX_BLOCKS);
  localparam logic [BW-1:0] MARK_FREE = BW'(MAX_BLOCKS + 1);
  localparam logic [IW-1:0] LAST_IDX  = IW'(MAX_BLOCKS - 1);

  state_t        state;
  state_t        state_next;

  logic [IW-1:0] clr_idx;
  logic          clr_fmt;
  logic [BW-1:0] scan_idx;
  logic          s1_valid;
  logic [IW-1:0] s1_idx;
  logic [BW-1:0] got;
  logic [BW-1:0] needed;
  logic [BW-1:0] prev;
  logic [BW-1:0] head;
  logic [BW-1:0] cur;
  logic [BW-1:0] steps;
  logic          walk_sat;
  logic          rd_ok;

  logic [BW-1:0] lim;
  logic          accept;
  logic          issue;
  logic          found;
  logic          scan_done;
  logic          walk_go;
  logic          alloc_skip;
  logic          idx_ok;

  // Working limit and shared conditions
  always_comb begin
    lim        = (disk_blocks > MARK_END) ? MARK_END : disk_blocks;
    accept     = in_valid && (state == ST_IDLE);
    issue      = (state == ST_SCAN) && (scan_idx < lim);
    found      = s1_valid && (ram_rdata == MARK_FREE);
    scan_done  = (found && ((got + BW'(1)) == needed)) || (!s1_valid && !issue);
    walk_go    = (cur < MARK_END) && (steps < lim);
    alloc_skip = (req_blocks == '0) || (req_blocks > free_left);
    idx_ok     = BW'(entry_index) < MARK_END;
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (clr_idx == LAST_IDX) begin
          state_next = clr_fmt ? ST_RESP : ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          unique case (cmd)
            CMD_FORMAT: state_next = ST_CLEAR;
            CMD_ALLOC:  state_next = alloc_skip ? ST_RESP : ST_SCAN;
            CMD_FREE:   state_next = ST_WALK_RD;
            CMD_READ:   state_next = ST_READ;
            default:    state_next = ST_IDLE;
          endcase
        end
      end
      ST_READ:     state_next = ST_RESP;
      ST_SCAN:     state_next = scan_done ? ST_LINK_END : ST_SCAN;
      ST_LINK_END: state_next = (got == needed) ? ST_RESP : ST_WALK_RD;
      ST_WALK_RD:  state_next = walk_go ? ST_WALK_WR : ST_RESP;
      ST_WALK_WR:  state_next = ST_WALK_RD;
      ST_RESP:     state_next = res_take ? ST_IDLE : ST_RESP;
      default:     state_next = ST_IDLE;
    endcase
  end

  // Handshake and RAM port control
  always_comb begin
    in_ready  = (state == ST_IDLE);
    res_valid = (state == ST_RESP);
    ram_we    = 1'b0;
    ram_waddr = clr_idx;
    ram_wdata = MARK_FREE;
    ram_re    = 1'b0;
    ram_raddr = scan_idx[IW-1:0];
    unique case (state)
      ST_CLEAR: begin
        ram_we = 1'b1;
      end
      ST_IDLE: begin
        ram_re    = accept && (cmd == CMD_READ) && idx_ok;
        ram_raddr = entry_index;
      end
      ST_SCAN: begin
        ram_re    = issue;
        ram_we    = found && (prev != MARK_END);
        ram_waddr = prev[IW-1:0];
        ram_wdata = BW'(s1_idx);
      end
      ST_LINK_END: begin
        ram_we    = (got == needed);
        ram_waddr = prev[IW-1:0];
        ram_wdata = MARK_END;
      end
      ST_WALK_RD: begin
        ram_re    = walk_go;
        ram_raddr = cur[IW-1:0];
      end
      ST_WALK_WR: begin
        ram_we    = 1'b1;
        ram_waddr = cur[IW-1:0];
      end
      ST_READ, ST_RESP: begin
      end
      default: begin
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_idx   <= '0;
      clr_fmt   <= 1'b0;
      s1_valid  <= 1'b0;
      free_left <= MARK_END;
    end else begin
      state <= state_next;
      // clearing pass
      if (state == ST_CLEAR) begin
        clr_idx <= clr_idx + IW'(1);
        if (clr_idx == LAST_IDX && clr_fmt) begin
          free_left <= lim;
        end
      end
      if (accept && cmd == CMD_FORMAT) begin
        clr_idx <= '0;
        clr_fmt <= 1'b1;
      end
      // scan read pipeline
      s1_valid <= issue && !scan_done;
      // commit a complete allocation
      if (state == ST_LINK_END && got == needed) begin
        free_left <= free_left - got;
      end
      // release counting saturates at the limit
      if (state == ST_WALK_WR && walk_sat && free_left < lim) begin
        free_left <= free_left + BW'(1);
      end
    end
  end

  // Working registers and result fields
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          res_ok    <= 1'b1;
          res_first <= MARK_END;
          res_count <= '0;
          res_value <= '0;
          rd_ok     <= idx_ok;
          needed    <= req_blocks;
          scan_idx  <= '0;
          got       <= '0;
          prev      <= MARK_END;
          head      <= MARK_END;
          cur       <= chain_head;
          steps     <= '0;
          walk_sat  <= 1'b1;
          if (cmd == CMD_ALLOC && req_blocks > free_left) begin
            res_ok <= 1'b0;
          end
        end
      end
      ST_READ: begin
        res_value <= rd_ok ? ram_rdata : MARK_FREE;
      end
      ST_SCAN: begin
        if (issue) begin
          scan_idx <= scan_idx + BW'(1);
          s1_idx   <= scan_idx[IW-1:0];
        end
        if (found) begin
          got  <= got + BW'(1);
          prev <= BW'(s1_idx);
          if (head == MARK_END) begin
            head <= BW'(s1_idx);
          end
        end
      end
      ST_LINK_END: begin
        if (got == needed) begin
          res_first <= head;
          res_count <= got;
        end else begin
          // roll the partial chain back without touching the count
          res_ok   <= 1'b0;
          cur      <= head;
          steps    <= '0;
          walk_sat <= 1'b0;
        end
      end
      ST_WALK_RD: begin
        if (!walk_go && walk_sat) begin
          res_count <= steps;
        end
      end
      ST_WALK_WR: begin
        cur   <= ram_rdata;
        steps <= steps + BW'(1);
      end
      ST_CLEAR, ST_RESP: begin
      end
      default: begin
      end
    endcase
  end

endmodule

FILE: rtl/fat_chain_block_allocator.sv
// Top level of the chain block allocator: configuration register, output register,
// link table RAM and controller. Depends on fcba_pkg, fcba_ram and fcba_ctrl.

// One command word is worked on at a time and gives exactly one result word. The
// link table sits in a single RAM with one write and one read port and registered
// read data, and that port pair sets the timing. After reset a clearing pass
// writes every one of the MAX_BLOCKS entries free, one a cycle, with in_ready
// low. Format repeats that pass. Allocate scans the table one entry a cycle, up
// to limit entries; when too few free blocks turn up, the blocks taken so far
// are walked and handed back. A zero or over-large request answers without a
// scan. Free walks the chain block by block. The next word is taken while a
// result waits in the output register.

module fat_chain_block_allocator #(
  parameter int MAX_BLOCKS = 1024
) (
  input  logic                            clk,
  input  logic                            rst,
  // configuration
  input  logic                            cfg_we,
  input  logic [$clog2(MAX_BLOCKS+2)-1:0] cfg_wdata,
  // input words
  input  logic                            in_valid,
  output logic                            in_ready,
  input  fcba_pkg::cmd_t                  cmd,
  input  logic [$clog2(MAX_BLOCKS+2)-1:0] req_blocks,
  input  logic [$clog2(MAX_BLOCKS+2)-1:0] chain_head,
  input  logic [$clog2(MAX_BLOCKS)-1:0]   entry_index,
  // result words
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            ok,
  output logic [$clog2(MAX_BLOCKS+2)-1:0] chain_first,
  output logic [$clog2(MAX_BLOCKS+2)-1:0] moved_blocks,
  output logic [$clog2(MAX_BLOCKS+2)-1:0] free_count,
  output logic [$clog2(MAX_BLOCKS+2)-1:0] entry_value
);

  import fcba_pkg::*;

  localparam int BW = $clog2(MAX_BLOCKS + 2);
  localparam int IW = $clog2(MAX_BLOCKS);
  localparam int TOTAL_RESET = (MAX_BLOCKS < 1024) ? MAX_BLOCKS : 1024;

  logic [BW-1:0] disk_blocks;
  logic          res_valid;
  logic          res_take;
  logic          res_ok;
  logic [BW-1:0] res_first;
  logic [BW-1:0] res_count;
  logic [BW-1:0] res_value;
  logic [BW-1:0] free_left;
  logic          ram_we;
  logic [IW-1:0] ram_waddr;
  logic [BW-1:0] ram_wdata;
  logic          ram_re;
  logic [IW-1:0] ram_raddr;
  logic [BW-1:0] ram_rdata;

  // Hold the block total
  always_ff @(posedge clk) begin
    if (rst) begin
      disk_blocks <= BW'(TOTAL_RESET);
    end else if (cfg_we) begin
      disk_blocks <= cfg_wdata;
    end
  end

  // Take a finished word whenever the output register is empty or draining
  assign res_take = res_valid && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_take) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Output word register
  always_ff @(posedge clk) begin
    if (res_take) begin
      ok           <= res_ok;
      chain_first  <= res_first;
      moved_blocks <= res_count;
      free_count   <= free_left;
      entry_value  <= res_value;
    end
  end

  fcba_ram #(
    .WIDTH (BW),
    .DEPTH (MAX_BLOCKS)
  ) u_link_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  fcba_ctrl #(
    .MAX_BLOCKS (MAX_BLOCKS),
    .BW         (BW),
    .IW         (IW)
  ) u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .cmd           (cmd),
    .req_blocks    (req_blocks),
    .chain_head    (chain_head),
    .entry_index   (entry_index),
    .disk_blocks   (disk_blocks),
    .res_valid     (res_valid),
    .res_take      (res_take),
    .res_ok        (res_ok),
    .res_first     (res_first),
    .res_count     (res_count),
    .res_value     (res_value),
    .free_left     (free_left),
    .ram_we        (ram_we),
    .ram_waddr     (ram_waddr),
    .ram_wdata     (ram_wdata),
    .ram_re        (ram_re),
    .ram_raddr     (ram_raddr),
    .ram_rdata     (ram_rdata)
  );

endmodule
